[rtl/core/mesh_fault_tolerant_route_select_assert.svh]
`ifndef MESH_FAULT_TOLERANT_ROUTE_SELECT_ASSERT_SVH
`define MESH_FAULT_TOLERANT_ROUTE_SELECT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define MFTRS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("route select: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define MFTRS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("route select: next-cycle check failed");

`endif

[rtl/core/mftrs_pkg.sv]
`default_nettype none

package mftrs_pkg;

  localparam int COORD_BITS  = 4;
  localparam int CREDIT_BITS = 4;
  localparam int ROWS_BITS   = COORD_BITS + 1;
  localparam int CFG_BITS    = ROWS_BITS;
  localparam int LFSR_BITS   = 16;

  localparam logic [LFSR_BITS-1:0] LFSR_SEED = 16'hACE1;

  // Port codes shared by the arrival and the chosen port.
  localparam logic [2:0] PORT_LOCAL = 3'd0;
  localparam logic [2:0] PORT_NORTH = 3'd1;
  localparam logic [2:0] PORT_SOUTH = 3'd2;
  localparam logic [2:0] PORT_WEST  = 3'd3;
  localparam logic [2:0] PORT_EAST  = 3'd4;

  // Configuration register indexes.
  localparam logic [1:0] CFG_ROUTER_X  = 2'd0;
  localparam logic [1:0] CFG_ROUTER_Y  = 2'd1;
  localparam logic [1:0] CFG_MESH_ROWS = 2'd2;
  localparam logic [1:0] CFG_FAULTY    = 2'd3;

  typedef struct packed {
    logic [COORD_BITS-1:0]  dest_x;
    logic [COORD_BITS-1:0]  dest_y;
    logic [COORD_BITS-1:0]  src_x;
    logic [COORD_BITS-1:0]  src_y;
    logic [2:0]             in_port;
    logic                   in_vc;
    logic [CREDIT_BITS-1:0] credit_east;
    logic [CREDIT_BITS-1:0] credit_west;
    logic [CREDIT_BITS-1:0] credit_north_vc0;
    logic [CREDIT_BITS-1:0] credit_north_vc1;
    logic [CREDIT_BITS-1:0] credit_south_vc0;
    logic [CREDIT_BITS-1:0] credit_south_vc1;
  } mftrs_in_t;

  typedef struct packed {
    logic [2:0] out_port;
    logic       out_vc;
    logic [2:0] from_port;
    logic       from_vc;
  } mftrs_out_t;

endpackage

`default_nettype wire

[rtl/core/mesh_fault_tolerant_route_select.sv]
`default_nettype none

// Route computation for one router of a 2D mesh: each head-flit beat on the
// in_ channel yields exactly one out_ beat carrying the chosen output port and
// VC plus the echoed arrival port and VC. The block is a two-register pipeline
// (input register, combinational route rules, result register), and one beat
// per cycle is sustained while out_stall stays low. Router position, mesh
// height and the neighbor fault flags are written through the cfg_ port; the
// user must write them only while no beat is in flight, which the block does
// not enforce. Credit ties and the free north/south choice take bit 0 of a
// 16-bit LFSR that steps only when such a draw is used.
module mesh_fault_tolerant_route_select (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          cfg_we,
  input  wire  [1:0]                   cfg_index,
  input  wire  [mftrs_pkg::CFG_BITS-1:0] cfg_wdata,
  input  wire                          in_valid,
  output logic                         in_stall,
  input  mftrs_pkg::mftrs_in_t         in_data,
  output logic                         out_valid,
  input  wire                          out_stall,
  output mftrs_pkg::mftrs_out_t        out_data
);
  import mftrs_pkg::*;

  typedef struct packed {
    logic [2:0] port;
    logic       vc;
  } sel_t;

  typedef struct packed {
    sel_t sel;
    logic draw;
  } route_t;

  localparam sel_t SEL_LOCAL = '{port: PORT_LOCAL, vc: 1'b0};
  localparam sel_t SEL_N0    = '{port: PORT_NORTH, vc: 1'b0};
  localparam sel_t SEL_S0    = '{port: PORT_SOUTH, vc: 1'b0};
  localparam sel_t SEL_W     = '{port: PORT_WEST,  vc: 1'b0};
  localparam sel_t SEL_E     = '{port: PORT_EAST,  vc: 1'b0};
  localparam sel_t SEL_N1    = '{port: PORT_NORTH, vc: 1'b1};
  localparam sel_t SEL_S1    = '{port: PORT_SOUTH, vc: 1'b1};

  logic [COORD_BITS-1:0] router_x_r;
  logic [COORD_BITS-1:0] router_y_r;
  logic [ROWS_BITS-1:0]  mesh_rows_r;
  logic [3:0]            faulty_r;
  logic [LFSR_BITS-1:0]  lfsr_r;
  logic [LFSR_BITS-1:0]  lfsr_nxt;

  logic       s1_valid_r;
  mftrs_in_t  s1_data_r;
  logic       out_valid_r;
  mftrs_out_t out_data_r;

  logic s2_ready;
  logic s1_move;
  logic in_accept;
  logic coin;

  logic [COORD_BITS-1:0] dx, dy, sx, sy, rx, ry, adx, ady;
  logic [ROWS_BITS-1:0]  ry_ext, dy_ext;
  logic                  f_n, f_s, f_w, f_e;
  logic                  north_is_dest, south_is_dest, on_south_edge;
  route_t                route;

  assign s2_ready  = !out_valid_r || !out_stall;
  assign s1_move   = s1_valid_r && s2_ready;
  assign in_stall  = s1_valid_r && !s2_ready;
  assign in_accept = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign dx  = s1_data_r.dest_x;
  assign dy  = s1_data_r.dest_y;
  assign sx  = s1_data_r.src_x;
  assign sy  = s1_data_r.src_y;
  assign rx  = router_x_r;
  assign ry  = router_y_r;
  assign adx = (dx > rx) ? dx - rx : rx - dx;
  assign ady = (dy > ry) ? dy - ry : ry - dy;
  assign f_n = faulty_r[0];
  assign f_s = faulty_r[1];
  assign f_w = faulty_r[2];
  assign f_e = faulty_r[3];
  assign coin = lfsr_r[0];

  // Neighbor tests are done one bit wider so no edge row wraps around.
  assign ry_ext        = {1'b0, ry};
  assign dy_ext        = {1'b0, dy};
  assign north_is_dest = (dx == rx) && (dy_ext + 1'b1 == ry_ext);
  assign south_is_dest = (dx == rx) && (dy_ext == ry_ext + 1'b1);
  assign on_south_edge = (mesh_rows_r != '0) && (ry_ext == mesh_rows_r - 1'b1);

  function automatic route_t diag_f(input logic fh, input logic fv,
                                    input logic [CREDIT_BITS-1:0] ch,
                                    input logic [CREDIT_BITS-1:0] cv,
                                    input sel_t h, input sel_t v);
    route_t r;
    r.draw = 1'b0;
    if (adx != '0 && ady == '0) begin
      r.sel = h;
    end else if (adx == '0 && ady != '0) begin
      r.sel = v;
    end else if (adx == 1 && ady != '0) begin
      r.sel = fv ? h : v;
    end else if (adx > 1 && ady == 1) begin
      r.sel = fh ? v : h;
    end else if (fh && !fv) begin
      r.sel = v;
    end else if (!fh && fv) begin
      r.sel = h;
    end else if (ch > cv) begin
      r.sel = h;
    end else if (ch < cv) begin
      r.sel = v;
    end else begin
      r.draw = 1'b1;
      r.sel  = coin ? v : h;
    end
    return r;
  endfunction

  function automatic route_t horiz_f(input logic fh, input sel_t h,
                                     input sel_t n, input sel_t s);
    route_t r;
    r.draw = 1'b0;
    if (dy == ry) begin
      if (!fh) begin
        r.sel = h;
      end else if (!f_n && f_s) begin
        r.sel = n;
      end else if (f_n && !f_s) begin
        r.sel = s;
      end else if (ry == '0) begin
        r.sel = s;
      end else if (on_south_edge) begin
        r.sel = n;
      end else begin
        r.draw = 1'b1;
        r.sel  = coin ? s : n;
      end
    end else if (north_is_dest) begin
      r.sel = n;
    end else if (south_is_dest) begin
      r.sel = s;
    end else if (fh && dy < ry && s1_data_r.in_port != PORT_NORTH) begin
      r.sel = n;
    end else if (fh && dy > ry && s1_data_r.in_port != PORT_SOUTH) begin
      r.sel = s;
    end else begin
      r.sel = h;
    end
    return r;
  endfunction

  function automatic route_t vert_f(input logic fv, input sel_t v);
    route_t r;
    r.draw = 1'b0;
    if (dx == rx) begin
      if (fv) begin
        r.sel = (rx != '0) ? SEL_W : SEL_E;
      end else begin
        r.sel = v;
      end
    end else if (dx > rx) begin
      if (s1_data_r.in_port != PORT_EAST && !f_e) begin
        r.sel = SEL_E;
      end else begin
        r.sel = (dy == ry) ? SEL_E : v;
      end
    end else begin
      if (s1_data_r.in_port != PORT_WEST && !f_w) begin
        r.sel = SEL_W;
      end else begin
        r.sel = (dy == ry) ? SEL_W : v;
      end
    end
    return r;
  endfunction

  always_comb begin
    if (rx == dx && ry == dy) begin
      route = '{sel: SEL_LOCAL, draw: 1'b0};
    end else if (sy == dy && sx < dx) begin
      route = horiz_f(f_e, SEL_E, SEL_N0, SEL_S0);
    end else if (sy == dy && sx > dx) begin
      route = horiz_f(f_w, SEL_W, SEL_N1, SEL_S1);
    end else if (sy > dy && sx == dx) begin
      route = vert_f(f_n, SEL_N1);
    end else if (sy < dy && sx == dx) begin
      route = vert_f(f_s, SEL_S1);
    end else if (sy > dy && sx < dx) begin
      route = diag_f(f_e, f_n, s1_data_r.credit_east, s1_data_r.credit_north_vc0,
                     SEL_E, SEL_N0);
    end else if (sy > dy && sx > dx) begin
      route = diag_f(f_w, f_n, s1_data_r.credit_west, s1_data_r.credit_north_vc1,
                     SEL_W, SEL_N1);
    end else if (sy < dy && sx < dx) begin
      route = diag_f(f_e, f_s, s1_data_r.credit_east, s1_data_r.credit_south_vc0,
                     SEL_E, SEL_S0);
    end else begin
      // Also covers a packet whose source equals its destination.
      route = diag_f(f_w, f_s, s1_data_r.credit_west, s1_data_r.credit_south_vc1,
                     SEL_W, SEL_S1);
    end
  end

  // Fibonacci LFSR, taps 16, 14, 13, 11; it steps only when a draw is used.
  always_comb begin
    lfsr_nxt = lfsr_r;
    if (s1_move && route.draw) begin
      lfsr_nxt = {lfsr_r[0] ^ lfsr_r[2] ^ lfsr_r[3] ^ lfsr_r[5], lfsr_r[LFSR_BITS-1:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      router_x_r  <= '0;
      router_y_r  <= '0;
      mesh_rows_r <= ROWS_BITS'(4);
      faulty_r    <= '0;
      lfsr_r      <= LFSR_SEED;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_ROUTER_X:  router_x_r  <= cfg_wdata[COORD_BITS-1:0];
          CFG_ROUTER_Y:  router_y_r  <= cfg_wdata[COORD_BITS-1:0];
          CFG_MESH_ROWS: mesh_rows_r <= cfg_wdata[ROWS_BITS-1:0];
          CFG_FAULTY:    faulty_r    <= cfg_wdata[3:0];
          default: ;
        endcase
      end
      lfsr_r      <= lfsr_nxt;
      s1_valid_r  <= in_accept || (s1_valid_r && !s1_move);
      out_valid_r <= s1_move || (out_valid_r && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_data_r <= in_data;
    end
    if (s1_move) begin
      out_data_r.out_port  <= route.sel.port;
      out_data_r.out_vc    <= route.sel.vc;
      out_data_r.from_port <= s1_data_r.in_port;
      out_data_r.from_vc   <= s1_data_r.in_vc;
    end
  end

  `include "mesh_fault_tolerant_route_select_assert.svh"

  `MFTRS_ASSERT_NOW(a_lfsr_nonzero, clk, rst_n, 1'b1, lfsr_r != '0)
  `MFTRS_ASSERT_NEXT(a_lfsr_holds, clk, rst_n, !(s1_move && route.draw), lfsr_r == $past(lfsr_r))
  `MFTRS_ASSERT_NEXT(a_beat_reaches_s1, clk, rst_n, in_accept, s1_valid_r)
  `MFTRS_ASSERT_NEXT(a_beat_reaches_out, clk, rst_n, s1_move, out_valid_r)
  `MFTRS_ASSERT_NOW(a_vc1_vertical, clk, rst_n, out_valid_r && out_data_r.out_vc,
                    out_data_r.out_port == PORT_NORTH || out_data_r.out_port == PORT_SOUTH)

endmodule

`default_nettype wire
